// ===== sv/modular_exponentiation_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit assertion macros
// Concurrent assertion wrappers; empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

`ifndef SYNTH
`define MEXP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MEXP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, register map, controller states and control/status words.
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int EXP_BITS = 32;
    localparam int MOD_BITS = 32;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = $clog2(WORD_W);
    localparam int PADDR_W  = 3;

    localparam logic        REG_MODULUS   = 1'b0;
    localparam logic [31:0] MODULUS_RESET = 32'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE_GO,
        ST_REDUCE_WAIT,
        ST_TEST,
        ST_MUL_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic red_start;
        logic red_load;
        logic mul_start;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic m_small;
        logic e_zero;
        logic unit_done;
    } dp_status_t;

endpackage

// ===== sv/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Computes a*x mod m, one multiplier bit per cycle, MSB first (a < m).
// ----------------------------------------------------------------------------
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [MOD_BITS-1:0] a,
    input  logic [WORD_W-1:0]   x,
    input  logic [MOD_BITS-1:0] m,
    output logic [MOD_BITS-1:0] result,
    output logic                done
);

    logic                run_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [WORD_W-1:0]   x_reg;
    logic [MOD_BITS-1:0] a_reg;
    logic [MOD_BITS-1:0] r_reg;

    logic [MOD_BITS:0]   m_ext;
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   dbl_red;
    logic [MOD_BITS-1:0] addend;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS:0]   sum_red;

    always_comb
    begin
        m_ext   = {1'b0, m};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        addend  = x_reg[WORD_W-1] ? a_reg : '0;
        sum     = {1'b0, dbl_red[MOD_BITS-1:0]} + {1'b0, addend};
        sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == '0);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(WORD_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            x_reg <= x;
            a_reg <= a;
        end
        else if (run_reg)
        begin
            r_reg <= sum_red[MOD_BITS-1:0];
            x_reg <= x_reg << 1;
        end
    end

    assign result = r_reg;
    assign done   = done_reg;

endmodule

// ===== sv/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation datapath
// Operand registers and two serial multipliers (reduce/square, accumulate).
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_macros.svh"

module mexp_dp
    import mexp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic [MOD_BITS-1:0] modulus,
    input  logic [31:0]         base_value,
    input  logic [31:0]         exponent,
    output logic [31:0]         residue,
    output logic                residue_valid,
    output dp_status_t          status
);

    logic [MOD_BITS-1:0] m_reg;
    logic [EXP_BITS-1:0] e_reg;
    logic [WORD_W-1:0]   base_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [31:0]         residue_reg;
    logic                valid_reg;

    logic                sq_start;
    logic [MOD_BITS-1:0] sq_a;
    logic [WORD_W-1:0]   sq_x;
    logic [MOD_BITS-1:0] sq_res;
    logic                sq_done;
    logic [MOD_BITS-1:0] ac_res;
    logic                ac_done;
    logic                m_small;

    assign m_small  = (m_reg < MOD_BITS'(2));
    assign sq_start = cmd.red_start | cmd.mul_start;
    assign sq_a     = cmd.red_start ? MOD_BITS'(1) : b_reg;
    assign sq_x     = cmd.red_start ? base_reg : WORD_W'(b_reg);

    mexp_mulmod u_sq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .a      (sq_a),
        .x      (sq_x),
        .m      (m_reg),
        .result (sq_res),
        .done   (sq_done)
    );

    mexp_mulmod u_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (b_reg),
        .x      (WORD_W'(acc_reg)),
        .m      (m_reg),
        .result (ac_res),
        .done   (ac_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg    <= modulus;
            e_reg    <= EXP_BITS'(exponent);
            base_reg <= WORD_W'(base_value);
            acc_reg  <= MOD_BITS'(1);
        end
        if (cmd.red_load)
            b_reg <= sq_res;
        if (cmd.step)
        begin
            if (e_reg[0])
                acc_reg <= ac_res;
            b_reg <= sq_res;
            e_reg <= e_reg >> 1;
        end
        if (cmd.finish)
            residue_reg <= m_small ? '0 : 32'(acc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.finish;
    end

    assign residue       = residue_reg;
    assign residue_valid = valid_reg;
    assign status        = '{m_small: m_small, e_zero: (e_reg == '0), unit_done: sq_done};

    `MEXP_ASSERT_SAME(a_res_below_mod, clk, rst_n, valid_reg, (residue_reg < 32'(m_reg)) || (m_reg < MOD_BITS'(2)))
    `MEXP_ASSERT_SAME(a_sq_below_mod, clk, rst_n, sq_done, sq_res < m_reg)
    `MEXP_ASSERT_SAME(a_units_in_step, clk, rst_n, cmd.step, sq_done && ac_done)

endmodule

// ===== sv/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation controller
// Base reduction, then square/multiply passes up to the top set exponent bit.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_unit_macros.svh"

module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_REDUCE_GO;
            end
            ST_REDUCE_GO:
            begin
                state_next = status.m_small ? ST_FINISH : ST_REDUCE_WAIT;
            end
            ST_REDUCE_WAIT:
            begin
                if (status.unit_done)
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = status.e_zero ? ST_FINISH : ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (status.unit_done)
                    state_next = ST_TEST;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_REDUCE_GO:
            begin
                cmd.red_start = !status.m_small;
            end
            ST_REDUCE_WAIT:
            begin
                cmd.red_load = status.unit_done;
            end
            ST_TEST:
            begin
                cmd.mul_start = !status.e_zero;
            end
            ST_MUL_WAIT:
            begin
                cmd.step = status.unit_done;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `MEXP_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, state_reg == ST_FINISH, state_reg == ST_IDLE)
    `MEXP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, start && !busy, state_reg == ST_REDUCE_GO)

endmodule

// ===== sv/modular_exponentiation_unit.sv =====
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// A word is accepted when start is high and busy is low; residue_valid marks
// the one cycle in which residue holds base_value^exponent mod modulus and must
// be taken, as the receiver cannot stall. One square/multiply pass runs for
// each exponent bit up to the highest set bit (none for a zero exponent);
// base reduction and all passes are skipped when the modulus is below two.
// The run time is set by the bit-serial modular multipliers, with the
// square and the multiply of each exponent bit running side by side. busy
// drops in the cycle residue_valid is high, so the next word may start then.
// The modulus register lies at APB address 0 and resets to 2.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        base_value,
    input  logic [31:0]        exponent,
    output logic [31:0]        residue,
    output logic               residue_valid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] modulus_reg;
    logic        reg_sel;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign reg_sel = (paddr[2] == REG_MODULUS);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? modulus_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MODULUS_RESET;
        else if (psel && penable && pwrite && reg_sel)
            modulus_reg <= pwdata;
    end

    mexp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mexp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .modulus       (modulus_reg[MOD_BITS-1:0]),
        .base_value    (base_value),
        .exponent      (exponent),
        .residue       (residue),
        .residue_valid (residue_valid),
        .status        (status)
    );

endmodule
